// File: design/udpg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// udpg_pkg
// shared types and constants of the udp header generator
// ----------------------------------------------------------------------------
package udpg_pkg;

    // configuration register indexes
    localparam logic [1:0] CFG_FRAME_LENGTH  = 2'd0;
    localparam logic [1:0] CFG_ADDRESS_COUNT = 2'd1;

    localparam int unsigned HDR_BYTES = 42;
    localparam logic [5:0]  LAST_POS  = 6'(HDR_BYTES - 1);

    localparam logic [15:0] FRAME_LENGTH_RESET = 16'd60;
    localparam logic [15:0] ETH_IP_OFFSET      = 16'd14;
    localparam logic [15:0] ETH_UDP_OFFSET     = 16'd34;

    localparam logic [7:0]  SRC_NET      = 8'h0A;
    localparam logic [15:0] DST_HI       = 16'hC0A8;
    localparam logic [15:0] DST_LO       = 16'h0001;
    localparam logic [15:0] IP_VER_TOS   = 16'h4500;
    localparam logic [15:0] IP_ID        = 16'd2012;
    localparam logic [15:0] IP_TTL_PROTO = 16'h4011;
    localparam logic [15:0] UDP_SRC_PORT = 16'd2014;
    localparam logic [15:0] UDP_DST_PORT = 16'd3000;
    localparam logic [7:0]  ETHERTYPE_HI = 8'h08;

    // sum of the header words that never change (flags/fragment word is zero)
    localparam logic [17:0] CSUM_BASE = 18'(IP_VER_TOS) + 18'(IP_ID) + 18'(IP_TTL_PROTO)
                                      + 18'({SRC_NET, 8'h00}) + 18'(DST_HI) + 18'(DST_LO);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_SUM,
        ST_PUSH
    } t_front_state;

    // per-packet values handed from the front to the serialiser
    typedef struct packed {
        logic [23:0] src_low;
        logic [15:0] csum;
    } t_hdr_job;

endpackage
`default_nettype wire

// File: design/udpg_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// udpg_front
// takes packet indexes, derives source address and ip header checksum
// ----------------------------------------------------------------------------
module udpg_front (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    output logic                      o_busy,
    input  wire logic [31:0]          i_packet_index,
    input  wire logic [15:0]          i_frame_length,
    input  wire logic [24:0]          i_address_count,
    input  wire logic                 i_q_full,
    output logic                      o_push,
    output udpg_pkg::t_hdr_job        o_job
);

    udpg_pkg::t_front_state r_state, n_state;
    logic [31:0] r_dvd, n_dvd;
    logic [24:0] r_rem, n_rem;
    logic [4:0]  r_cnt, n_cnt;
    logic [23:0] r_src, n_src;
    logic [15:0] r_csum, n_csum;

    logic        accept;
    logic        cnt_zero;
    logic        cnt_one;
    logic        cnt_pow2;
    logic [25:0] trial;
    logic [25:0] trial_sub;
    logic [15:0] ip_len;
    logic [17:0] sum;
    logic [16:0] fold1;
    logic [15:0] fold2;

    assign accept   = i_start && (r_state == udpg_pkg::ST_IDLE);
    assign cnt_zero = (i_address_count == 25'd0);
    assign cnt_one  = (i_address_count == 25'd1);
    assign cnt_pow2 = ((i_address_count & (i_address_count - 25'd1)) == 25'd0);

    // one restoring remainder step
    assign trial     = {r_rem, r_dvd[31]};
    assign trial_sub = trial - {1'b0, i_address_count};

    assign ip_len = i_frame_length - udpg_pkg::ETH_IP_OFFSET;
    assign sum    = udpg_pkg::CSUM_BASE + 18'(ip_len) + 18'(r_src[23:16]) + 18'(r_src[15:0]);
    assign fold1  = 17'(sum[15:0]) + 17'(sum[17:16]);
    assign fold2  = fold1[15:0] + 16'(fold1[16]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= udpg_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_dvd  <= n_dvd;
        r_rem  <= n_rem;
        r_cnt  <= n_cnt;
        r_src  <= n_src;
        r_csum <= n_csum;
    end

    always_comb begin
        n_state = r_state;
        n_dvd   = r_dvd;
        n_rem   = r_rem;
        n_cnt   = r_cnt;
        n_src   = r_src;
        n_csum  = r_csum;
        o_push  = 1'b0;
        case (r_state)
            udpg_pkg::ST_IDLE: begin
                if (accept) begin
                    n_dvd = i_packet_index;
                    n_rem = '0;
                    n_cnt = 5'd31;
                    if (cnt_zero) begin
                        n_src   = i_packet_index[23:0];
                        n_state = udpg_pkg::ST_SUM;
                    end else if (cnt_one) begin
                        n_src   = '0;
                        n_state = udpg_pkg::ST_SUM;
                    end else if (cnt_pow2) begin
                        n_src   = i_packet_index[23:0] & 24'(i_address_count - 25'd1);
                        n_state = udpg_pkg::ST_SUM;
                    end else begin
                        n_state = udpg_pkg::ST_DIV;
                    end
                end
            end
            udpg_pkg::ST_DIV: begin
                n_dvd = {r_dvd[30:0], 1'b0};
                if (!trial_sub[25]) begin
                    n_rem = trial_sub[24:0];
                end else begin
                    n_rem = trial[24:0];
                end
                n_cnt = r_cnt - 5'd1;
                if (r_cnt == 5'd0) begin
                    n_src   = n_rem[23:0];
                    n_state = udpg_pkg::ST_SUM;
                end
            end
            udpg_pkg::ST_SUM: begin
                n_csum  = ~fold2;
                n_state = udpg_pkg::ST_PUSH;
            end
            udpg_pkg::ST_PUSH: begin
                if (!i_q_full) begin
                    o_push  = 1'b1;
                    n_state = udpg_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = udpg_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_busy        = (r_state != udpg_pkg::ST_IDLE);
    assign o_job.src_low = r_src;
    assign o_job.csum    = r_csum;

endmodule
`default_nettype wire

// File: design/udpg_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// udpg_queue
// short flop fifo of header jobs between front and serialiser
// ----------------------------------------------------------------------------
module udpg_queue #(
    parameter int DEPTH = 2
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_push,
    input  wire udpg_pkg::t_hdr_job   i_job,
    output logic                      o_full,
    input  wire logic                 i_pop,
    output logic                      o_empty,
    output udpg_pkg::t_hdr_job        o_head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    udpg_pkg::t_hdr_job r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_fill, n_fill;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= '0;
            r_rd   <= '0;
            r_fill <= '0;
        end else begin
            r_wr   <= n_wr;
            r_rd   <= n_rd;
            r_fill <= n_fill;
        end
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_comb begin
        n_wr   = r_wr;
        n_rd   = r_rd;
        n_fill = r_fill;
        if (i_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_fill = r_fill + CNT_W'(1);
        end else if (i_pop && !i_push) begin
            n_fill = r_fill - CNT_W'(1);
        end
    end

    assign o_full  = (r_fill == CNT_W'(DEPTH));
    assign o_empty = (r_fill == '0);
    assign o_head  = r_mem[r_rd];

endmodule
`default_nettype wire

// File: design/udpg_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// udpg_back
// serialises one header job into 42 bytes, one per cycle
// ----------------------------------------------------------------------------
module udpg_back (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_empty,
    input  wire udpg_pkg::t_hdr_job   i_head,
    output logic                      o_pop,
    input  wire logic [15:0]          i_frame_length,
    output logic                      o_strobe,
    output logic [7:0]                o_header_byte,
    output logic [5:0]                o_byte_position,
    output logic                      o_last_byte
);

    udpg_pkg::t_hdr_job r_job;
    logic       r_active, n_active;
    logic [5:0] r_pos, n_pos;
    logic       r_strobe;
    logic [7:0] r_byte, n_byte;
    logic [5:0] r_out_pos;
    logic       r_last;

    logic [15:0] ip_len;
    logic [15:0] udp_len;
    logic        at_end;

    assign ip_len  = i_frame_length - udpg_pkg::ETH_IP_OFFSET;
    assign udp_len = i_frame_length - udpg_pkg::ETH_UDP_OFFSET;
    assign at_end  = (r_pos == udpg_pkg::LAST_POS);
    assign o_pop   = !i_empty && (!r_active || at_end);

    always_comb begin
        n_active = r_active;
        n_pos    = r_pos;
        if (o_pop) begin
            n_active = 1'b1;
            n_pos    = '0;
        end else if (r_active) begin
            if (at_end) begin
                n_active = 1'b0;
            end else begin
                n_pos = r_pos + 6'd1;
            end
        end
    end

    // byte at the current offset
    always_comb begin
        case (r_pos)
            6'd12:   n_byte = udpg_pkg::ETHERTYPE_HI;
            6'd14:   n_byte = udpg_pkg::IP_VER_TOS[15:8];
            6'd16:   n_byte = ip_len[15:8];
            6'd17:   n_byte = ip_len[7:0];
            6'd18:   n_byte = udpg_pkg::IP_ID[15:8];
            6'd19:   n_byte = udpg_pkg::IP_ID[7:0];
            6'd22:   n_byte = udpg_pkg::IP_TTL_PROTO[15:8];
            6'd23:   n_byte = udpg_pkg::IP_TTL_PROTO[7:0];
            6'd24:   n_byte = r_job.csum[15:8];
            6'd25:   n_byte = r_job.csum[7:0];
            6'd26:   n_byte = udpg_pkg::SRC_NET;
            6'd27:   n_byte = r_job.src_low[23:16];
            6'd28:   n_byte = r_job.src_low[15:8];
            6'd29:   n_byte = r_job.src_low[7:0];
            6'd30:   n_byte = udpg_pkg::DST_HI[15:8];
            6'd31:   n_byte = udpg_pkg::DST_HI[7:0];
            6'd32:   n_byte = udpg_pkg::DST_LO[15:8];
            6'd33:   n_byte = udpg_pkg::DST_LO[7:0];
            6'd34:   n_byte = udpg_pkg::UDP_SRC_PORT[15:8];
            6'd35:   n_byte = udpg_pkg::UDP_SRC_PORT[7:0];
            6'd36:   n_byte = udpg_pkg::UDP_DST_PORT[15:8];
            6'd37:   n_byte = udpg_pkg::UDP_DST_PORT[7:0];
            6'd38:   n_byte = udp_len[15:8];
            6'd39:   n_byte = udp_len[7:0];
            default: n_byte = (r_pos < 6'd12) ? {2'b00, r_pos} : 8'h00;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_active <= n_active;
            r_strobe <= r_active;
        end
        r_pos     <= n_pos;
        r_byte    <= n_byte;
        r_out_pos <= r_pos;
        r_last    <= at_end;
        if (o_pop) begin
            r_job <= i_head;
        end
    end

    assign o_strobe        = r_strobe;
    assign o_header_byte   = r_byte;
    assign o_byte_position = r_out_pos;
    assign o_last_byte     = r_strobe && r_last;

endmodule
`default_nettype wire

// File: design/udp_header_generator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// udp_header_generator
// emits the 42-byte ethernet/ipv4/udp header for each packet index
// ----------------------------------------------------------------------------
// a packet index is taken when start is high and busy is low; the block then
// emits 42 header bytes, one per cycle on o_strobe, last byte marked by
// o_last_byte. the receiver cannot stall: every strobed byte is taken as it
// appears. the sustained packet rate is set by the byte serialiser. the
// front derives the source directly for zero, one or power-of-two address
// counts and by a 32-step bit-serial remainder otherwise, busy all the while;
// up to QUEUE_DEPTH finished jobs wait for the serialiser, so busy also stays
// high while a finished job waits for a full queue. a job from an empty queue
// is popped into the serialiser, then its first byte is registered out.
// configuration: index 0 frame_length, index 1 address_count; writes are
// always taken (o_cfg_ready tied high) and must be issued while idle
// ----------------------------------------------------------------------------
module udp_header_generator #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // request side
    input  wire logic        start,
    output logic             busy,
    input  wire logic [31:0] i_packet_index,
    // configuration write channel
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [24:0] i_cfg_data,
    // header byte stream
    output logic             o_strobe,
    output logic [7:0]       o_header_byte,
    output logic [5:0]       o_byte_position,
    output logic             o_last_byte
);

    logic [15:0] r_frame_length;
    logic [24:0] r_address_count;

    udpg_pkg::t_hdr_job push_job;
    udpg_pkg::t_hdr_job head_job;
    logic q_push;
    logic q_pop;
    logic q_full;
    logic q_empty;
    logic cfg_wr;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    // configuration registers, unknown indexes are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_length  <= udpg_pkg::FRAME_LENGTH_RESET;
            r_address_count <= '0;
        end else if (cfg_wr) begin
            case (i_cfg_index)
                udpg_pkg::CFG_FRAME_LENGTH:  r_frame_length  <= i_cfg_data[15:0];
                udpg_pkg::CFG_ADDRESS_COUNT: r_address_count <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // front: source address and header checksum per request
    udpg_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .o_busy          (busy),
        .i_packet_index  (i_packet_index),
        .i_frame_length  (r_frame_length),
        .i_address_count (r_address_count),
        .i_q_full        (q_full),
        .o_push          (q_push),
        .o_job           (push_job)
    );

    // decoupling queue
    udpg_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (push_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_head  (head_job)
    );

    // back: byte serialiser with registered outputs
    udpg_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_empty         (q_empty),
        .i_head          (head_job),
        .o_pop           (q_pop),
        .i_frame_length  (r_frame_length),
        .o_strobe        (o_strobe),
        .o_header_byte   (o_header_byte),
        .o_byte_position (o_byte_position),
        .o_last_byte     (o_last_byte)
    );

endmodule
`default_nettype wire

// File: design/udpg_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// udpg_checker
// port-level checks of the header byte stream
// ----------------------------------------------------------------------------
module udpg_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       start,
    input wire logic       busy,
    input wire logic       o_strobe,
    input wire logic [5:0] o_byte_position,
    input wire logic       o_last_byte
);

    a_last_needs_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last_byte |-> o_strobe)
        else $error("last mark without strobe");

    a_last_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_last_byte) |-> (o_byte_position == udpg_pkg::LAST_POS))
        else $error("last mark not on final offset");

    a_bytes_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_last_byte) |=>
            (o_strobe && (o_byte_position == $past(o_byte_position) + 6'd1)))
        else $error("gap or skip inside a header");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after request");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_strobe)
        else $error("strobe after reset");

endmodule

bind udp_header_generator udpg_checker u_udpg_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .o_strobe        (o_strobe),
    .o_byte_position (o_byte_position),
    .o_last_byte     (o_last_byte)
);
`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the udp header generator: packet index requests
// go in with random gaps, every strobed header byte is compared against a
// locally built ethernet/ipv4/udp header, under several register settings
// ----------------------------------------------------------------------------
module tb;

    // register indexes that decode to nothing
    localparam logic [1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [1:0] CFG_SPARE_3 = 2'd3;

    localparam int RANDOM_ITEMS   = 250;
    localparam int SETTLE_CYCLES  = 8;
    localparam int TAIL_CYCLES    = 50;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int MAX_REPORTS    = 10;

    typedef struct packed {
        logic [7:0] hdr;
        logic [5:0] pos;
        logic       last;
    } t_hdr_byte;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [31:0] i_packet_index = '0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [24:0] i_cfg_data = '0;
    logic        o_strobe;
    logic [7:0]  o_header_byte;
    logic [5:0]  o_byte_position;
    logic        o_last_byte;

    // local copy of the two registers, tracked on each accepted write
    logic [15:0] model_frame_length = udpg_pkg::FRAME_LENGTH_RESET;
    logic [24:0] model_address_count = '0;

    // header bytes still owed by the block, oldest first
    t_hdr_byte pending_bytes[$];

    int mismatch_count = 0;
    int idle_cycles = 0;

    udp_header_generator u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_packet_index  (i_packet_index),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_strobe        (o_strobe),
        .o_header_byte   (o_header_byte),
        .o_byte_position (o_byte_position),
        .o_last_byte     (o_last_byte)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // builds the 42 header bytes for one index and queues them
    function automatic void queue_header_bytes(input logic [31:0] idx);
        logic [7:0]  h [0:41];
        logic [31:0] n;
        logic [31:0] src_low;
        logic [31:0] src;
        logic [31:0] acc;
        logic [15:0] ip_len;
        logic [15:0] udp_len;
        t_hdr_byte   b;
        n = 32'(model_address_count);
        // source host bits: raw index, fixed, masked or reduced modulo the count
        if (n == 0)
            src_low = idx & 32'h00FF_FFFF;
        else if (n == 1)
            src_low = '0;
        else if ((n & (n - 1)) == 0)
            src_low = idx & (n - 1) & 32'h00FF_FFFF;
        else
            src_low = (idx % n) & 32'h00FF_FFFF;
        src     = 32'h0A00_0000 | src_low;
        // length fields wrap for short frames
        ip_len  = model_frame_length - 16'd14;
        udp_len = model_frame_length - 16'd34;
        for (int k = 0; k < 12; k++)
            h[k] = 8'(k);
        h[12] = 8'h08;
        h[13] = 8'h00;
        h[14] = 8'h45;
        h[15] = 8'h00;
        h[16] = ip_len[15:8];
        h[17] = ip_len[7:0];
        h[18] = 8'h07;
        h[19] = 8'hDC;
        h[20] = 8'h00;
        h[21] = 8'h00;
        h[22] = 8'd64;
        h[23] = 8'd17;
        h[24] = 8'h00;
        h[25] = 8'h00;
        for (int k = 0; k < 4; k++) begin
            h[26 + k] = 8'(src >> (24 - 8 * k));
            h[30 + k] = 8'(32'hC0A8_0001 >> (24 - 8 * k));
        end
        // ones' complement sum with end-around carry, check field at zero
        acc = '0;
        for (int k = 14; k < 34; k += 2) begin
            acc = acc + {16'h0000, h[k], h[k + 1]};
            if (acc > 32'h0000_FFFF)
                acc = acc - 32'h0000_FFFF;
        end
        acc   = ~acc & 32'h0000_FFFF;
        h[24] = acc[15:8];
        h[25] = acc[7:0];
        h[34] = 8'h07;
        h[35] = 8'hDE;
        h[36] = 8'h0B;
        h[37] = 8'hB8;
        h[38] = udp_len[15:8];
        h[39] = udp_len[7:0];
        h[40] = 8'h00;
        h[41] = 8'h00;
        for (int k = 0; k < udpg_pkg::HDR_BYTES; k++) begin
            b.hdr  = h[k];
            b.pos  = 6'(k);
            b.last = (k == udpg_pkg::HDR_BYTES - 1);
            pending_bytes.push_back(b);
        end
    endfunction

    task automatic note_failure(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("mismatch: %s", msg);
    endtask

    // one packet index request: random gap, then hold start until taken
    task automatic send_index(input logic [31:0] idx);
        int gap;
        gap = $urandom_range(0, 6);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start          <= 1'b1;
        i_packet_index <= idx;
        forever begin
            @(posedge i_clk);
            if (!busy)
                break;
        end
        // taken at this edge
        queue_header_bytes(idx);
    endtask

    // register write; the extra edge keeps valid from toggling twice in a step
    task automatic write_reg(input logic [1:0] idx, input logic [24:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        forever begin
            @(posedge i_clk);
            if (o_cfg_ready)
                break;
        end
        if (idx == udpg_pkg::CFG_FRAME_LENGTH)
            model_frame_length = data[15:0];
        else if (idx == udpg_pkg::CFG_ADDRESS_COUNT)
            model_address_count = data;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // stop requesting and wait until every owed byte has come out
    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_bytes.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // reset values: frame length 60, source taken straight from the index
    task automatic test_reset_defaults();
        send_index(32'h0000_0000);
        send_index(32'hFFFF_FFFF);
        send_index(32'h00FF_FFFF);
        send_index(32'h0100_0000);
        drain();
    endtask

    // each way of deriving the source host bits
    task automatic test_address_modes();
        // fixed source
        write_reg(udpg_pkg::CFG_ADDRESS_COUNT, 25'd1);
        send_index(32'hFFFF_FFFF);
        send_index(32'h1234_5678);
        drain();
        // power of two, small and full 24-bit mask
        write_reg(udpg_pkg::CFG_ADDRESS_COUNT, 25'd16);
        send_index(32'hFFFF_FFFF);
        drain();
        write_reg(udpg_pkg::CFG_ADDRESS_COUNT, 25'h100_0000);
        send_index(32'hFFFF_FFFF);
        drain();
        // counts beyond 2^24 go through the remainder and are then cut
        write_reg(udpg_pkg::CFG_ADDRESS_COUNT, 25'h100_0001);
        send_index(32'hFFFF_FFFF);
        drain();
        write_reg(udpg_pkg::CFG_ADDRESS_COUNT, 25'h1FF_FFFF);
        send_index(32'hFFFF_FFFF);
        drain();
        // plain remainder
        write_reg(udpg_pkg::CFG_ADDRESS_COUNT, 25'd3);
        send_index(32'hFFFF_FFFF);
        send_index(32'h8000_0000);
        drain();
        write_reg(udpg_pkg::CFG_ADDRESS_COUNT, 25'hFF_FFFF);
        send_index(32'hFFFF_FFFF);
        drain();
        write_reg(udpg_pkg::CFG_ADDRESS_COUNT, 25'd0);
    endtask

    // length extremes, including frames too short for the length fields
    task automatic test_frame_lengths();
        write_reg(udpg_pkg::CFG_FRAME_LENGTH, 25'd42);
        send_index(32'h0000_0001);
        drain();
        write_reg(udpg_pkg::CFG_FRAME_LENGTH, 25'd65535);
        send_index(32'h0000_0002);
        drain();
        write_reg(udpg_pkg::CFG_FRAME_LENGTH, 25'd0);
        send_index(32'h0000_0003);
        drain();
        write_reg(udpg_pkg::CFG_FRAME_LENGTH, 25'd13);
        send_index(32'h0000_0004);
        drain();
        write_reg(udpg_pkg::CFG_FRAME_LENGTH, 25'd33);
        send_index(32'h0000_0005);
        drain();
    endtask

    // writes to undecoded indexes must leave both registers alone
    task automatic test_spare_indexes();
        write_reg(udpg_pkg::CFG_FRAME_LENGTH, 25'd100);
        write_reg(CFG_SPARE_2, 25'h1FF_FFFF);
        write_reg(CFG_SPARE_3, 25'h1FF_FFFF);
        send_index(32'hA5A5_5A5A);
        drain();
    endtask

    // random phases: fresh settings per phase, random indexes within it
    task automatic test_random_traffic();
        int          sent;
        int          burst;
        logic [31:0] idx;
        logic [24:0] count;
        logic [15:0] flen;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 5))
                0: flen = 16'd42;
                1: flen = 16'd65535;
                2: flen = udpg_pkg::FRAME_LENGTH_RESET;
                3: flen = 16'($urandom);
                4: flen = 16'($urandom_range(42, 1518));
                default: flen = 16'($urandom_range(0, 41));
            endcase
            case ($urandom_range(0, 5))
                0: count = '0;
                1: count = 25'd1;
                2: count = 25'd1 << $urandom_range(1, 24);
                3: count = 25'($urandom_range(2, 100));
                4: count = 25'($urandom);
                default: count = 25'h100_0000 + 25'($urandom_range(0, 32'hFF_FFFF));
            endcase
            // order of the two writes varies from phase to phase
            if ($urandom_range(0, 1)) begin
                write_reg(udpg_pkg::CFG_FRAME_LENGTH, 25'(flen));
                write_reg(udpg_pkg::CFG_ADDRESS_COUNT, count);
            end else begin
                write_reg(udpg_pkg::CFG_ADDRESS_COUNT, count);
                write_reg(udpg_pkg::CFG_FRAME_LENGTH, 25'(flen));
            end
            burst = $urandom_range(8, 30);
            for (int k = 0; k < burst; k++) begin
                case ($urandom_range(0, 3))
                    0: idx = $urandom;
                    1: idx = 32'($urandom_range(0, 255));
                    // land on or next to a multiple of the count
                    2: idx = 32'(model_address_count) * 32'($urandom_range(0, 255))
                             + 32'($urandom_range(0, 1)) - 32'd1;
                    default: idx = {$urandom_range(0, 1) ? 8'hFF : 8'h00, 24'($urandom)};
                endcase
                send_index(idx);
                sent++;
            end
            drain();
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        test_reset_defaults();
        test_address_modes();
        test_frame_lengths();
        test_spare_indexes();
        test_random_traffic();
        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_bytes.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // every strobed byte is taken at this edge and checked against the oldest owed one
    always @(posedge i_clk) begin : byte_check
        t_hdr_byte want;
        if (i_rst_n && o_strobe) begin
            if (pending_bytes.size() == 0) begin
                note_failure($sformatf("unexpected byte %02h pos %0d last %0d",
                                       o_header_byte, o_byte_position, o_last_byte));
            end else begin
                want = pending_bytes.pop_front();
                if (o_header_byte !== want.hdr || o_byte_position !== want.pos
                        || o_last_byte !== want.last)
                    note_failure($sformatf(
                        "pos %0d: expected byte %02h pos %0d last %0d, got %02h %0d %0d",
                        want.pos, want.hdr, want.pos, want.last,
                        o_header_byte, o_byte_position, o_last_byte));
            end
        end
    end

    // run is stuck when no request, byte or register write moves for too long
    always @(posedge i_clk) begin
        if ((start && !busy) || o_strobe || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

endmodule
